// File: rtl/monf_pkg.sv
// Package: widths, codes, axis masks and direction table for the Morton neighbor finder.
`default_nettype none

package monf_pkg;

    localparam int C_CODE_W    = 57;
    localparam int C_DEPTH_W   = 5;
    localparam int C_DIR_W     = 5;
    localparam int C_STATUS_W  = 3;
    localparam int C_SHIFT_W   = 7;
    localparam int C_MAX_DEPTH = 19;
    localparam int C_NUM_DIRS  = 26;

    localparam logic [C_DEPTH_W-1:0] C_TREE_DEPTH_RST = C_DEPTH_W'(19);
    localparam logic [C_DEPTH_W-1:0] C_DEPTH_LIMIT    = C_DEPTH_W'(C_MAX_DEPTH);

    localparam logic [C_CODE_W-1:0] C_CODE_ONES = {C_CODE_W{1'b1}};
    localparam logic [C_CODE_W-1:0] C_AXIS_X =
        57'b001001001001001001001001001001001001001001001001001001001;
    localparam logic [C_CODE_W-1:0] C_AXIS_Y =
        57'b010010010010010010010010010010010010010010010010010010010;
    localparam logic [C_CODE_W-1:0] C_AXIS_Z =
        57'b100100100100100100100100100100100100100100100100100100100;
    localparam logic [C_CODE_W-1:0] C_UNIT_X = C_CODE_W'(1);
    localparam logic [C_CODE_W-1:0] C_UNIT_Y = C_CODE_W'(2);
    localparam logic [C_CODE_W-1:0] C_UNIT_Z = C_CODE_W'(4);

    typedef enum logic [C_STATUS_W-1:0] {
        ST_FOUND   = 3'd0,
        ST_DEPTH   = 3'd1,
        ST_ROOT    = 3'd2,
        ST_OUTSIDE = 3'd3,
        ST_BAD_DIR = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_INC,
        STEP_DEC
    } t_step;

    typedef struct packed {
        t_step x;
        t_step y;
        t_step z;
    } t_move;

    typedef enum logic [C_DIR_W-1:0] {
        DIR_BSW, DIR_BW, DIR_BNW, DIR_BN, DIR_B, DIR_BS, DIR_BSE, DIR_BE, DIR_BNE,
        DIR_SW, DIR_W, DIR_NW, DIR_N, DIR_S, DIR_SE, DIR_E, DIR_NE,
        DIR_ASW, DIR_AW, DIR_ANW, DIR_AN, DIR_A, DIR_AS, DIR_ASE, DIR_AE, DIR_ANE
    } t_dir;

    function automatic t_move dir_move(input logic [C_DIR_W-1:0] dir);
        t_move mv;
        mv = '{STEP_NONE, STEP_NONE, STEP_NONE};
        unique case (t_dir'(dir))
            DIR_BSW: mv = '{STEP_DEC,  STEP_DEC,  STEP_DEC};
            DIR_BW:  mv = '{STEP_DEC,  STEP_DEC,  STEP_NONE};
            DIR_BNW: mv = '{STEP_DEC,  STEP_DEC,  STEP_INC};
            DIR_BN:  mv = '{STEP_NONE, STEP_DEC,  STEP_INC};
            DIR_B:   mv = '{STEP_NONE, STEP_DEC,  STEP_NONE};
            DIR_BS:  mv = '{STEP_NONE, STEP_DEC,  STEP_DEC};
            DIR_BSE: mv = '{STEP_INC,  STEP_DEC,  STEP_DEC};
            DIR_BE:  mv = '{STEP_INC,  STEP_DEC,  STEP_NONE};
            DIR_BNE: mv = '{STEP_INC,  STEP_DEC,  STEP_INC};
            DIR_SW:  mv = '{STEP_DEC,  STEP_NONE, STEP_DEC};
            DIR_W:   mv = '{STEP_DEC,  STEP_NONE, STEP_NONE};
            DIR_NW:  mv = '{STEP_DEC,  STEP_NONE, STEP_INC};
            DIR_N:   mv = '{STEP_NONE, STEP_NONE, STEP_INC};
            DIR_S:   mv = '{STEP_NONE, STEP_NONE, STEP_DEC};
            DIR_SE:  mv = '{STEP_INC,  STEP_NONE, STEP_DEC};
            DIR_E:   mv = '{STEP_INC,  STEP_NONE, STEP_NONE};
            DIR_NE:  mv = '{STEP_INC,  STEP_NONE, STEP_INC};
            DIR_ASW: mv = '{STEP_DEC,  STEP_INC,  STEP_DEC};
            DIR_AW:  mv = '{STEP_DEC,  STEP_INC,  STEP_NONE};
            DIR_ANW: mv = '{STEP_DEC,  STEP_INC,  STEP_INC};
            DIR_AN:  mv = '{STEP_NONE, STEP_INC,  STEP_INC};
            DIR_A:   mv = '{STEP_NONE, STEP_INC,  STEP_NONE};
            DIR_AS:  mv = '{STEP_NONE, STEP_INC,  STEP_DEC};
            DIR_ASE: mv = '{STEP_INC,  STEP_INC,  STEP_DEC};
            DIR_AE:  mv = '{STEP_INC,  STEP_INC,  STEP_NONE};
            DIR_ANE: mv = '{STEP_INC,  STEP_INC,  STEP_INC};
            default: mv = '{STEP_NONE, STEP_NONE, STEP_NONE};
        endcase
        return mv;
    endfunction

endpackage

`default_nettype wire

// File: rtl/monf_in_if.sv
// Interface: input channel carrying one cell query item.
`default_nettype none

interface monf_in_if import monf_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [C_CODE_W-1:0]  cell_code;
    logic [C_DEPTH_W-1:0] cell_depth;
    logic [C_DIR_W-1:0]   direction;

    modport source (output valid, cell_code, cell_depth, direction, input ready);
    modport sink   (input valid, cell_code, cell_depth, direction, output ready);
endinterface

`default_nettype wire

// File: rtl/monf_out_if.sv
// Interface: output channel carrying one neighbor result item.
`default_nettype none

interface monf_out_if import monf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [C_CODE_W-1:0]   neighbor_code;
    logic [C_STATUS_W-1:0] status;

    modport source (output valid, neighbor_code, status, input ready);
    modport sink   (input valid, neighbor_code, status, output ready);
endinterface

`default_nettype wire

// File: rtl/monf_axis.sv
// Masked dilated-integer step of one axis of a Morton code.
`default_nettype none

module monf_axis import monf_pkg::*; (
    input  logic [C_CODE_W-1:0] i_code,
    input  logic [C_CODE_W-1:0] i_mask,
    input  logic [C_CODE_W-1:0] i_unit,
    input  t_step               i_step,
    output logic [C_CODE_W-1:0] o_bits,
    output logic                o_outside
);

    logic [C_CODE_W-1:0] part;
    logic [C_CODE_W-1:0] inc_bits;
    logic [C_CODE_W-1:0] dec_bits;

    assign part     = i_code & i_mask;
    assign inc_bits = ((i_code | ~i_mask) + i_unit) & i_mask;
    assign dec_bits = (part - i_unit) & i_mask;

    always_comb begin
        unique case (i_step)
            STEP_INC: begin
                o_bits    = inc_bits;
                o_outside = (part == i_mask);
            end
            STEP_DEC: begin
                o_bits    = dec_bits;
                o_outside = (part == '0);
            end
            default: begin
                o_bits    = part;
                o_outside = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/monf_core.sv
// Neighbor code and status for one registered query item.
`default_nettype none

module monf_core import monf_pkg::*; (
    input  logic [C_CODE_W-1:0]   i_code,
    input  logic [C_DEPTH_W-1:0]  i_depth,
    input  logic [C_DIR_W-1:0]    i_dir,
    input  logic [C_DEPTH_W-1:0]  i_tree_depth,
    output logic [C_CODE_W-1:0]   o_code,
    output t_status               o_status
);

    logic [C_DEPTH_W-1:0] limit;
    logic [C_SHIFT_W-1:0] shamt;
    logic [C_CODE_W-1:0]  width_mask;
    logic [C_CODE_W-1:0]  code_m;
    logic [C_CODE_W-1:0]  bits_x;
    logic [C_CODE_W-1:0]  bits_y;
    logic [C_CODE_W-1:0]  bits_z;
    logic                 out_x;
    logic                 out_y;
    logic                 out_z;
    t_move                mv;

    assign limit      = (i_tree_depth > C_DEPTH_LIMIT) ? C_DEPTH_LIMIT : i_tree_depth;
    assign shamt      = C_SHIFT_W'(i_depth) * C_SHIFT_W'(3);
    assign width_mask = ~(C_CODE_ONES << shamt);
    assign code_m     = i_code & width_mask;
    assign mv         = dir_move(i_dir);

    monf_axis u_axis_x (
        .i_code    (code_m),
        .i_mask    (C_AXIS_X & width_mask),
        .i_unit    (C_UNIT_X),
        .i_step    (mv.x),
        .o_bits    (bits_x),
        .o_outside (out_x)
    );

    monf_axis u_axis_y (
        .i_code    (code_m),
        .i_mask    (C_AXIS_Y & width_mask),
        .i_unit    (C_UNIT_Y),
        .i_step    (mv.y),
        .o_bits    (bits_y),
        .o_outside (out_y)
    );

    monf_axis u_axis_z (
        .i_code    (code_m),
        .i_mask    (C_AXIS_Z & width_mask),
        .i_unit    (C_UNIT_Z),
        .i_step    (mv.z),
        .o_bits    (bits_z),
        .o_outside (out_z)
    );

    always_comb begin
        o_code = '0;
        priority if (i_depth > limit) begin
            o_status = ST_DEPTH;
        end else if (i_depth == '0) begin
            o_status = ST_ROOT;
        end else if (i_dir >= C_DIR_W'(C_NUM_DIRS)) begin
            o_status = ST_BAD_DIR;
        end else if (out_x || out_y || out_z) begin
            o_status = ST_OUTSIDE;
        end else begin
            o_status = ST_FOUND;
            o_code   = bits_x | bits_y | bits_z;
        end
    end

endmodule

`default_nettype wire

// File: rtl/morton_octree_neighbor_finder_top.sv
// Top level: equal-depth neighbor finder for 3D Morton cell codes.
// Each item passes the input register, then the result register, from input accept to result valid.
// Throughput: one item per cycle unless the output stalls; one 57-bit masked add per axis.
// Both stages advance together whenever the result register is empty or being taken.
// Reset (synchronous, active low) empties both stages and sets tree_depth to 19.
`default_nettype none

module morton_octree_neighbor_finder_top import monf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [C_DEPTH_W-1:0] i_cfg_wdata,
    monf_in_if.sink              i_in,
    monf_out_if.source           o_out
);

    logic [C_DEPTH_W-1:0]  r_tree_depth;
    logic                  r_s1_valid;
    logic [C_CODE_W-1:0]   r_s1_code;
    logic [C_DEPTH_W-1:0]  r_s1_depth;
    logic [C_DIR_W-1:0]    r_s1_dir;
    logic                  r_out_valid;
    logic [C_CODE_W-1:0]   r_out_code;
    logic [C_STATUS_W-1:0] r_out_status;

    logic [C_CODE_W-1:0]   n_out_code;
    t_status               n_out_status;
    logic                  advance;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_depth <= C_TREE_DEPTH_RST;
        end else if (i_cfg_we) begin
            r_tree_depth <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_code  <= i_in.cell_code;
            r_s1_depth <= i_in.cell_depth;
            r_s1_dir   <= i_in.direction;
        end
    end

    monf_core u_core (
        .i_code       (r_s1_code),
        .i_depth      (r_s1_depth),
        .i_dir        (r_s1_dir),
        .i_tree_depth (r_tree_depth),
        .o_code       (n_out_code),
        .o_status     (n_out_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_code   <= n_out_code;
            r_out_status <= C_STATUS_W'(n_out_status);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.neighbor_code = r_out_code;
    assign o_out.status        = r_out_status;

endmodule

`default_nettype wire
